// ===== rtl/core/npcm_pkg.sv =====
`default_nettype none

package npcm_pkg;

    localparam int CH_W    = 8;
    localparam int COLOR_W = 16;
    localparam int CNT_W   = 9;
    localparam int FIELD_W = 5;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 20;

    localparam int OPAQUE_BIT = 15;

    localparam logic [CH_W-1:0]   ALPHA_OPAQUE = 8'd128;
    localparam logic [CNT_W-1:0]  COUNT_RESET  = 9'd16;
    localparam logic [DIST_W-1:0] WEIGHT_R     = 20'd3;
    localparam logic [DIST_W-1:0] WEIGHT_G     = 20'd6;
    localparam logic [DIST_W-1:0] WEIGHT_B     = 20'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               kind;
        logic [CH_W-1:0]    entry_index;
        logic [COLOR_W-1:0] entry_color;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
        logic [CH_W-1:0]    alpha;
        logic               last_pixel;
    } t_in_item;

    typedef struct packed {
        logic wr_entry;
        logic start;
        logic step;
        logic load_result;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic count_zero;
        logic busy;
    } t_dp_sts;

    // Widens a 5-bit channel to 8 bits by replicating its top bits.
    function automatic logic [CH_W-1:0] widen5(input logic [FIELD_W-1:0] v);
        return {v, v[FIELD_W-1:FIELD_W-3]};
    endfunction

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/npcm_in_if.sv =====
`default_nettype none

interface npcm_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [npcm_pkg::CH_W-1:0]    entry_index;
    logic [npcm_pkg::COLOR_W-1:0] entry_color;
    logic [npcm_pkg::CH_W-1:0]    red;
    logic [npcm_pkg::CH_W-1:0]    green;
    logic [npcm_pkg::CH_W-1:0]    blue;
    logic [npcm_pkg::CH_W-1:0]    alpha;
    logic                         last_pixel;

    modport source (
        output valid, kind, entry_index, entry_color, red, green, blue, alpha, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_index, entry_color, red, green, blue, alpha, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/npcm_out_if.sv =====
`default_nettype none

interface npcm_out_if;
    logic                      valid;
    logic                      ready;
    logic [npcm_pkg::CH_W-1:0] palette_index;
    logic                      end_of_image;

    modport source (
        output valid, palette_index, end_of_image,
        input  ready
    );
    modport sink (
        input  valid, palette_index, end_of_image,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/npcm_ctrl.sv =====
`default_nettype none

module npcm_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_kind,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output npcm_pkg::t_dp_cmd    o_cmd,
    input  npcm_pkg::t_dp_sts    i_sts
);

    npcm_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= npcm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            npcm_pkg::S_IDLE: begin
                if (i_in_valid && i_kind == npcm_pkg::KIND_PIXEL) begin
                    n_state = i_sts.count_zero ? npcm_pkg::S_DONE : npcm_pkg::S_SCAN;
                end
            end
            npcm_pkg::S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = npcm_pkg::S_DRAIN;
                end
            end
            npcm_pkg::S_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = npcm_pkg::S_DONE;
                end
            end
            npcm_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = npcm_pkg::S_IDLE;
                end
            end
            default: n_state = npcm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            npcm_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.wr_entry = i_in_valid && i_kind == npcm_pkg::KIND_WRITE;
                o_cmd.start    = i_in_valid && i_kind == npcm_pkg::KIND_PIXEL;
            end
            npcm_pkg::S_SCAN: begin
                o_cmd.step = 1'b1;
            end
            npcm_pkg::S_DRAIN: begin
            end
            npcm_pkg::S_DONE: begin
                o_cmd.load_result = !r_out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    // The result register frees up in the same cycle its transfer completes.
    always_comb begin
        if (o_cmd.load_result) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/core/npcm_dpath.sv =====
`default_nettype none

module npcm_dpath #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [npcm_pkg::CNT_W-1:0]          i_cfg_data,
    input  npcm_pkg::t_in_item                  i_item,
    input  npcm_pkg::t_dp_cmd                   i_cmd,
    output npcm_pkg::t_dp_sts                   o_sts,
    output logic [npcm_pkg::CH_W-1:0]           o_palette_index,
    output logic                                o_end_of_image
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [npcm_pkg::CNT_W-1:0] DEPTH_C = npcm_pkg::CNT_W'(PALETTE_DEPTH);

    logic [npcm_pkg::COLOR_W-1:0] mem [PALETTE_DEPTH];

    logic [npcm_pkg::CNT_W-1:0]   r_count;
    logic [npcm_pkg::CNT_W-1:0]   eff_count;
    logic [AW-1:0]                r_addr;

    logic [npcm_pkg::CH_W-1:0]    r_red, r_green, r_blue;
    logic                         r_opaque_wanted;
    logic                         r_last;

    // Three-stage search pipe: memory read, squared differences, weighted sum.
    logic                         r_v1, r_v2, r_v3;
    logic [AW-1:0]                r_idx1, r_idx2, r_idx3;
    logic [npcm_pkg::COLOR_W-1:0] r_rdata;
    logic [npcm_pkg::SQ_W-1:0]    r_sq_r, r_sq_g, r_sq_b;
    logic                         r_op2, r_op3;
    logic [npcm_pkg::DIST_W-1:0]  r_dist3;

    logic                         r_any_found, r_class_found;
    logic [AW-1:0]                r_best_any, r_best_class;
    logic [npcm_pkg::DIST_W-1:0]  r_any_dist, r_class_dist;

    logic [AW-1:0]                chosen;
    logic                         upd_any, upd_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= npcm_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    assign eff_count = (r_count > DEPTH_C) ? DEPTH_C : r_count;

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.scan_last  = (npcm_pkg::CNT_W'(r_addr) + 9'd1) == eff_count;
    assign o_sts.busy       = r_v1 || r_v2 || r_v3;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry &&
            npcm_pkg::CNT_W'(i_item.entry_index) < DEPTH_C) begin
            mem[i_item.entry_index[AW-1:0]] <= i_item.entry_color;
        end
        if (i_cmd.step) begin
            r_rdata <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_red           <= i_item.red;
            r_green         <= i_item.green;
            r_blue          <= i_item.blue;
            r_opaque_wanted <= i_item.alpha >= npcm_pkg::ALPHA_OPAQUE;
            r_last          <= i_item.last_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_addr <= '0;
            end else if (i_cmd.step) begin
                r_addr <= r_addr + AW'(1);
            end
            r_v1 <= i_cmd.step;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_idx1 <= r_addr;
        end
        if (r_v1) begin
            r_idx2 <= r_idx1;
            r_op2  <= r_rdata[npcm_pkg::OPAQUE_BIT];
            r_sq_r <= npcm_pkg::sq_diff(r_red,
                          npcm_pkg::widen5(r_rdata[4:0]));
            r_sq_g <= npcm_pkg::sq_diff(r_green,
                          npcm_pkg::widen5(r_rdata[9:5]));
            r_sq_b <= npcm_pkg::sq_diff(r_blue,
                          npcm_pkg::widen5(r_rdata[14:10]));
        end
        if (r_v2) begin
            r_idx3  <= r_idx2;
            r_op3   <= r_op2;
            r_dist3 <= npcm_pkg::DIST_W'(r_sq_r) * npcm_pkg::WEIGHT_R
                     + npcm_pkg::DIST_W'(r_sq_g) * npcm_pkg::WEIGHT_G
                     + npcm_pkg::DIST_W'(r_sq_b) * npcm_pkg::WEIGHT_B;
        end
    end

    // Strict less-than keeps the lowest index on ties.
    assign upd_any   = r_v3 && (!r_any_found || r_dist3 < r_any_dist);
    assign upd_class = r_v3 && (r_op3 == r_opaque_wanted) &&
                       (!r_class_found || r_dist3 < r_class_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any_found   <= 1'b0;
            r_class_found <= 1'b0;
        end else if (i_cmd.start) begin
            r_any_found   <= 1'b0;
            r_class_found <= 1'b0;
        end else begin
            if (upd_any) begin
                r_any_found <= 1'b1;
            end
            if (upd_class) begin
                r_class_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_any) begin
            r_any_dist <= r_dist3;
            r_best_any <= r_idx3;
        end
        if (upd_class) begin
            r_class_dist <= r_dist3;
            r_best_class <= r_idx3;
        end
    end

    // With no entry of the wanted opacity, fall back to the overall best.
    always_comb begin
        priority if (r_class_found) begin
            chosen = r_best_class;
        end else if (r_any_found) begin
            chosen = r_best_any;
        end else begin
            chosen = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            o_palette_index <= npcm_pkg::CH_W'(chosen);
            o_end_of_image  <= r_last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nearest_palette_color_match.sv =====
`default_nettype none

// Maps RGBA pixels to the index of the nearest entry of a palette of RGB555
// words (bit 15 marks an entry as opaque), with distance 3*dr^2 + 6*dg^2 +
// 2*db^2 and ties going to the lowest index. Pixels with alpha of 128 or more
// search only opaque entries, others only transparent ones; if the wanted
// class is empty, the overall nearest entry is returned. A palette write item
// gives no result. A pixel item searches the first N entries, where N is
// the search count register capped at PALETTE_DEPTH; with a count of zero
// no entry is read. The search walks the palette memory through its single
// read port, one entry per cycle, and a four-deep pipe of read, square,
// weight and compare trails the walk. A finished result waits in an output
// register, so the next item can be taken while the previous result is still
// unclaimed; a second finished result holds the input off until the first
// transfer completes. Palette entries must be written before a search reads
// them.
module nearest_palette_color_match #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [npcm_pkg::CNT_W-1:0]   i_cfg_data,
    npcm_in_if.sink                      i_pix,
    npcm_out_if.source                   o_res
);

    npcm_pkg::t_dp_cmd  cmd;
    npcm_pkg::t_dp_sts  sts;
    npcm_pkg::t_in_item item;

    assign item.kind        = i_pix.kind;
    assign item.entry_index = i_pix.entry_index;
    assign item.entry_color = i_pix.entry_color;
    assign item.red         = i_pix.red;
    assign item.green       = i_pix.green;
    assign item.blue        = i_pix.blue;
    assign item.alpha       = i_pix.alpha;
    assign item.last_pixel  = i_pix.last_pixel;

    npcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_kind      (i_pix.kind),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    npcm_dpath #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_item          (item),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_palette_index (o_res.palette_index),
        .o_end_of_image  (o_res.end_of_image)
    );

endmodule

`default_nettype wire

// ===== dv/tb_nearest_palette_color_match.sv =====
`timescale 1ns / 1ps

module tb_nearest_palette_color_match;

    localparam int DEPTH         = 256;
    localparam int ITEM_TARGET   = 1750;
    localparam int QUIET_AFTER   = 1450;
    localparam int SETTLE_CYCLES = 300;
    localparam int LONG_HOLD     = 400;

    typedef struct packed {
        logic [npcm_pkg::CH_W-1:0] palette_index;
        logic                      end_of_image;
    } t_match;

    // Keeps a shadow of the palette and the search count, and queues the
    // expected match for every pixel transfer in input order.
    class palette_scoreboard;
        logic [npcm_pkg::COLOR_W-1:0] palette [DEPTH];
        logic [npcm_pkg::CNT_W-1:0]   search_count;
        t_match                       pending_matches [$];
        int unsigned                  errors;

        function new();
            search_count = npcm_pkg::COUNT_RESET;
            errors = 0;
        endfunction

        static function logic [npcm_pkg::CH_W-1:0] expand5(
                logic [npcm_pkg::FIELD_W-1:0] v);
            return (npcm_pkg::CH_W'(v) << 3) | (npcm_pkg::CH_W'(v) >> 2);
        endfunction

        function int unsigned weighted_distance(logic [npcm_pkg::COLOR_W-1:0] word,
                                                logic [npcm_pkg::CH_W-1:0] r,
                                                logic [npcm_pkg::CH_W-1:0] g,
                                                logic [npcm_pkg::CH_W-1:0] b);
            int dr, dg, db;
            dr = int'(r) - int'(expand5(word[4:0]));
            dg = int'(g) - int'(expand5(word[9:5]));
            db = int'(b) - int'(expand5(word[14:10]));
            return 3 * dr * dr + 6 * dg * dg + 2 * db * db;
        endfunction

        function t_match nearest_entry(npcm_pkg::t_in_item px);
            t_match      m;
            int          n;
            bit          opaque_wanted, class_hit, any_hit;
            int unsigned d, class_dist, any_dist;
            int          class_idx, any_idx;
            n = (search_count > DEPTH) ? DEPTH : int'(search_count);
            opaque_wanted = (px.alpha >= npcm_pkg::ALPHA_OPAQUE);
            class_hit = 0;
            any_hit = 0;
            class_dist = 0;
            any_dist = 0;
            class_idx = 0;
            any_idx = 0;
            for (int i = 0; i < n; i++) begin
                d = weighted_distance(palette[i], px.red, px.green, px.blue);
                if (!any_hit || d < any_dist) begin
                    any_hit = 1;
                    any_dist = d;
                    any_idx = i;
                end
                if ((palette[i][npcm_pkg::OPAQUE_BIT] == opaque_wanted) &&
                    (!class_hit || d < class_dist)) begin
                    class_hit = 1;
                    class_dist = d;
                    class_idx = i;
                end
            end
            // An empty opacity class falls back to the overall nearest entry.
            m.palette_index = npcm_pkg::CH_W'(class_hit ? class_idx : any_idx);
            m.end_of_image = px.last_pixel;
            return m;
        endfunction

        function void set_count(logic [npcm_pkg::CNT_W-1:0] c);
            search_count = c;
        endfunction

        function void note_input(npcm_pkg::t_in_item it);
            if (it.kind == npcm_pkg::KIND_WRITE) begin
                palette[it.entry_index] = it.entry_color;
            end else begin
                pending_matches.push_back(nearest_entry(it));
            end
        endfunction

        function void check_result(logic [npcm_pkg::CH_W-1:0] idx, logic eoi);
            t_match m;
            if (pending_matches.size() == 0) begin
                $error("unexpected result: palette_index %0d, end_of_image %0d", idx, eoi);
                errors++;
                return;
            end
            m = pending_matches.pop_front();
            if (idx !== m.palette_index) begin
                $error("palette_index: expected %0d, actual %0d", m.palette_index, idx);
                errors++;
            end
            if (eoi !== m.end_of_image) begin
                $error("end_of_image: expected %0d, actual %0d", m.end_of_image, eoi);
                errors++;
            end
        endfunction

        function int pending();
            return pending_matches.size();
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       cfg_we;
    logic [npcm_pkg::CNT_W-1:0] cfg_data;

    npcm_in_if  pix_if ();
    npcm_out_if res_if ();

    nearest_palette_color_match #(
        .PALETTE_DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    palette_scoreboard sb = new();

    bit                           written [DEPTH];
    logic [npcm_pkg::COLOR_W-1:0] loaded  [DEPTH];
    int                           sent_total = 0;
    bit                           quiet = 0;
    bit                           hold_req = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request so the
    // block fills up and pushes back on its input.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_if.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                res_if.ready = 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge i_clk);
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_result(res_if.palette_index, res_if.end_of_image);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input npcm_pkg::t_in_item it);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            pix_if.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        pix_if.kind        = it.kind;
        pix_if.entry_index = it.entry_index;
        pix_if.entry_color = it.entry_color;
        pix_if.red         = it.red;
        pix_if.green       = it.green;
        pix_if.blue        = it.blue;
        pix_if.alpha       = it.alpha;
        pix_if.last_pixel  = it.last_pixel;
        pix_if.valid       = 1'b1;
        do @(posedge i_clk); while (!pix_if.ready);
        sb.note_input(it);
        if (it.kind == npcm_pkg::KIND_WRITE) begin
            written[it.entry_index] = 1;
            loaded[it.entry_index] = it.entry_color;
        end
        sent_total++;
        if (sent_total >= QUIET_AFTER) quiet = 1;
        @(negedge i_clk);
    endtask

    // Fields that the item's kind does not use carry random junk.
    function automatic npcm_pkg::t_in_item write_item(int idx,
                                                      logic [npcm_pkg::COLOR_W-1:0] color);
        npcm_pkg::t_in_item it;
        it = npcm_pkg::t_in_item'({$urandom, $urandom});
        it.kind = npcm_pkg::KIND_WRITE;
        it.entry_index = npcm_pkg::CH_W'(idx);
        it.entry_color = color;
        return it;
    endfunction

    function automatic npcm_pkg::t_in_item pixel_item(int r, int g, int b, int a, bit last);
        npcm_pkg::t_in_item it;
        it = npcm_pkg::t_in_item'({$urandom, $urandom});
        it.kind = npcm_pkg::KIND_PIXEL;
        it.red = npcm_pkg::CH_W'(r);
        it.green = npcm_pkg::CH_W'(g);
        it.blue = npcm_pkg::CH_W'(b);
        it.alpha = npcm_pkg::CH_W'(a);
        it.last_pixel = last;
        return it;
    endfunction

    // Occasionally copies a loaded color so that equal distances come up.
    function automatic logic [npcm_pkg::COLOR_W-1:0] pick_color(int bias, int lim);
        logic [npcm_pkg::COLOR_W-1:0] c;
        int                           k;
        c = npcm_pkg::COLOR_W'($urandom);
        if (lim > 0 && $urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, lim - 1);
            if (written[k]) c = loaded[k];
        end
        if (bias == 0) c[npcm_pkg::OPAQUE_BIT] = 1'b0;
        else if (bias == 1) c[npcm_pkg::OPAQUE_BIT] = 1'b1;
        return c;
    endfunction

    function automatic int near_channel(logic [npcm_pkg::FIELD_W-1:0] v);
        int x;
        x = int'(palette_scoreboard::expand5(v)) + int'($urandom_range(0, 6)) - 3;
        return (x < 0) ? 0 : ((x > 255) ? 255 : x);
    endfunction

    function automatic int pick_alpha();
        case ($urandom_range(0, 5))
            0: begin
                return 127;
            end
            1: begin
                return 128;
            end
            2: begin
                return 0;
            end
            3: begin
                return 255;
            end
            default: begin
                return $urandom_range(0, 255);
            end
        endcase
    endfunction

    // The register only changes once the block has drained.
    task automatic set_palette_count(input logic [npcm_pkg::CNT_W-1:0] c);
        pix_if.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_data = c;
        @(negedge i_clk);
        cfg_we = 1'b0;
        sb.set_count(c);
    endtask

    initial begin
        int                           p, cnt, lim, bias, per_phase, k, i;
        logic [npcm_pkg::COLOR_W-1:0] word;
        logic [npcm_pkg::COLOR_W-1:0] seed_colors [8];

        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        pix_if.valid = 1'b0;
        pix_if.kind = npcm_pkg::KIND_WRITE;
        pix_if.entry_index = '0;
        pix_if.entry_color = '0;
        pix_if.red = '0;
        pix_if.green = '0;
        pix_if.blue = '0;
        pix_if.alpha = '0;
        pix_if.last_pixel = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset count of sixteen: black and white in
        // both classes, a duplicate opaque black to check the tie rule, and
        // pure primaries.
        seed_colors = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF,
                        16'h8000, 16'h801F, 16'h83E0, 16'hFC00};
        for (i = 0; i < 16; i++) begin
            word = (i < 8) ? seed_colors[i] : npcm_pkg::COLOR_W'($urandom);
            send_item(write_item(i, word));
        end
        send_item(pixel_item(0, 0, 0, 255, 0));
        send_item(pixel_item(255, 255, 255, 128, 0));
        send_item(pixel_item(0, 0, 0, 127, 0));
        send_item(pixel_item(255, 255, 255, 0, 1));
        send_item(pixel_item(255, 0, 0, 200, 0));
        send_item(pixel_item(0, 255, 0, 255, 0));
        send_item(pixel_item(0, 0, 255, 128, 1));
        send_item(pixel_item(128, 128, 128, 64, 0));
        send_item(pixel_item(255, 255, 255, 255, 1));

        p = 0;
        while (sent_total < ITEM_TARGET) begin
            case (p)
                0: begin
                    cnt = 1;
                end
                1: begin
                    cnt = 0;
                end
                2: begin
                    cnt = 256;
                end
                3: begin
                    cnt = 511;
                end
                4: begin
                    cnt = 3;
                end
                5: begin
                    cnt = 255;
                end
                default: begin
                    cnt = $urandom_range(1, 48);
                end
            endcase
            lim = (cnt > DEPTH) ? DEPTH : cnt;
            // A one-class bias writes new entries in that opacity class only.
            bias = $urandom_range(0, 2);
            per_phase = (lim > 64) ? 40 : 150;
            set_palette_count(npcm_pkg::CNT_W'(cnt));
            for (i = 0; i < lim; i++) begin
                if (!written[i]) send_item(write_item(i, pick_color(bias, lim)));
            end
            if (p == 4) hold_req = 1;
            for (i = 0; i < per_phase && sent_total < ITEM_TARGET; i++) begin
                if ($urandom_range(0, 9) < 3) begin
                    k = (lim > 0 && $urandom_range(0, 9) < 6) ?
                        $urandom_range(0, lim - 1) : $urandom_range(0, DEPTH - 1);
                    send_item(write_item(k, pick_color(bias, lim)));
                end else if (lim > 0 && $urandom_range(0, 1) == 0) begin
                    word = loaded[$urandom_range(0, lim - 1)];
                    send_item(pixel_item(near_channel(word[4:0]), near_channel(word[9:5]),
                                         near_channel(word[14:10]), pick_alpha(),
                                         $urandom_range(0, 7) == 0));
                end else begin
                    send_item(pixel_item($urandom_range(0, 255), $urandom_range(0, 255),
                                         $urandom_range(0, 255), pick_alpha(),
                                         $urandom_range(0, 7) == 0));
                end
            end
            p++;
        end

        pix_if.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
